@@ hw/rtl/dhcp_pkg.sv @@
// Shared types and constants for the DHCP reply parser.
package dhcp_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] source_port;
    logic [31:0] source_ip;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  message_type;
    logic [31:0] offered_ip;
    logic [31:0] server_addr;
    logic [31:0] subnet_mask;
    logic        mask_seen;
    logic [31:0] router_ip;
    logic        router_seen;
    logic [31:0] dns_ip;
    logic        dns_seen;
  } out_t;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_XID      = 3'd2;
  localparam logic [2:0] ST_MAGIC    = 3'd3;
  localparam logic [2:0] ST_PORT     = 3'd4;

  localparam int HEADER_BYTES  = 240;
  localparam int XID_END_POS   = 7;
  localparam int OFFER_END_POS = 19;

  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
  localparam logic [15:0] SERVER_PORT  = 16'd67;

  localparam logic [7:0] TAG_PAD     = 8'd0;
  localparam logic [7:0] TAG_SUBNET  = 8'd1;
  localparam logic [7:0] TAG_ROUTER  = 8'd3;
  localparam logic [7:0] TAG_DNS     = 8'd6;
  localparam logic [7:0] TAG_MSGTYPE = 8'd53;
  localparam logic [7:0] TAG_END     = 8'd255;

endpackage

@@ hw/rtl/dhcp_reply_parser.sv @@
// DHCP reply parser: header checks and option walk, one byte per cycle unless the output stalls.
// Throughput: one byte per cycle unless a full output register is stalled; it frees while being read.
// The result is registered and shows in the cycle after the transfer of the last byte.
// All work sits between the per-message state registers and the result register.
// Reset (rst, synchronous): clears the transaction id, message state and out_valid.
// Per-message state returns to its reset value after every last byte.
module dhcp_reply_parser #(
  parameter int OPTION_AREA_BYTES = 312
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dhcp_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dhcp_pkg::out_t   out_data,
  input  logic             cfg_write_en,
  input  logic [31:0]      cfg_write_data
);
  import dhcp_pkg::*;

  // Message length and widths that follow from the option area size.
  localparam int TOTAL_BYTES = HEADER_BYTES + OPTION_AREA_BYTES;
  localparam int POS_W       = $clog2(TOTAL_BYTES + 1);
  localparam int OFF_W       = $clog2(OPTION_AREA_BYTES);
  localparam int NOS_W       = $clog2(OPTION_AREA_BYTES + 1);
  localparam int SUM_W       = $clog2(OPTION_AREA_BYTES + 257);

  typedef enum logic [3:0] {
    PH_TAG   = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // Configuration.
  logic [31:0] transaction_id;

  // Per-message state.
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      hdr, hdr_next;
  logic             xid_ok, xid_ok_next;
  logic             magic_ok, magic_ok_next;
  logic             port_ok, port_ok_next;
  logic [31:0]      src, src_next;
  logic [31:0]      offered, offered_next;
  logic [NOS_W-1:0] nos, nos_next;
  phase_t           phase, phase_next;
  logic [7:0]       tag, tag_next;
  logic [2:0]       vcnt, vcnt_next;
  logic [31:0]      vshift, vshift_next;
  logic [7:0]       msg_type, msg_type_next;
  logic             type_pending, type_pending_next;
  logic [31:0]      mask, mask_next;
  logic             mask_seen, mask_seen_next;
  logic [31:0]      router, router_next;
  logic             router_seen, router_seen_next;
  logic [31:0]      dns, dns_next;
  logic             dns_seen, dns_seen_next;

  logic             accept;
  logic [OFF_W-1:0] off;
  logic [SUM_W-1:0] off1;
  logic [SUM_W-1:0] opt_end;
  logic [7:0]       b;
  out_t             res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign opt_end  = SUM_W'(OPTION_AREA_BYTES);

  // Offset into the option area; meaningful only once pos has passed the header.
  assign off  = OFF_W'(pos - POS_W'(HEADER_BYTES));
  assign off1 = SUM_W'(off) + SUM_W'(1);

  always_comb begin
    pos_next          = pos;
    hdr_next          = hdr;
    xid_ok_next       = xid_ok;
    magic_ok_next     = magic_ok;
    port_ok_next      = port_ok;
    src_next          = src;
    offered_next      = offered;
    nos_next          = nos;
    phase_next        = phase;
    tag_next          = tag;
    vcnt_next         = vcnt;
    vshift_next       = vshift;
    msg_type_next     = msg_type;
    type_pending_next = type_pending;
    mask_next         = mask;
    mask_seen_next    = mask_seen;
    router_next       = router;
    router_seen_next  = router_seen;
    dns_next          = dns;
    dns_seen_next     = dns_seen;
    res               = '0;

    if (accept) begin
      // Sample the source address and port on the first byte.
      if (pos == '0) begin
        src_next     = in_data.source_ip;
        port_ok_next = (in_data.source_port == SERVER_PORT);
      end

      // Bytes past the option area are dropped; pos saturates.
      if (pos < POS_W'(TOTAL_BYTES)) begin
        hdr_next = {hdr[23:0], b};
        pos_next = pos + POS_W'(1);
        if (pos == POS_W'(XID_END_POS)) begin
          xid_ok_next = (hdr_next == transaction_id);
        end else if (pos == POS_W'(OFFER_END_POS)) begin
          offered_next = hdr_next;
        end else if (pos == POS_W'(HEADER_BYTES - 1)) begin
          magic_ok_next = (hdr_next == MAGIC_COOKIE);
        end else if (pos >= POS_W'(HEADER_BYTES)) begin
          // The byte right after an option 53 length is the message type.
          if (type_pending) begin
            msg_type_next     = b;
            type_pending_next = 1'b0;
          end
          case (phase)
            PH_TAG: begin
              if (off1 >= opt_end || b == TAG_END) begin
                phase_next = PH_DONE;
              end else if (b != TAG_PAD) begin
                tag_next   = b;
                phase_next = PH_LEN;
              end
            end
            PH_LEN: begin
              if (off1 + SUM_W'(b) > opt_end) begin
                phase_next = PH_DONE;
              end else begin
                nos_next    = NOS_W'(off1 + SUM_W'(b));
                vshift_next = '0;
                vcnt_next   = '0;
                if (tag == TAG_MSGTYPE) begin
                  if (off1 >= opt_end) begin
                    msg_type_next = '0;
                  end else begin
                    type_pending_next = 1'b1;
                  end
                end
                phase_next = (b == 8'd0) ? PH_TAG : PH_VALUE;
              end
            end
            PH_VALUE: begin
              // Only the first four value bytes matter.
              if (vcnt < 3'd4) begin
                vshift_next = {vshift[23:0], b};
                vcnt_next   = vcnt + 3'd1;
              end
              if (vcnt == 3'd3) begin
                if (tag == TAG_SUBNET) begin
                  mask_next      = vshift_next;
                  mask_seen_next = 1'b1;
                end else if (tag == TAG_ROUTER) begin
                  router_next      = vshift_next;
                  router_seen_next = 1'b1;
                end else if (tag == TAG_DNS) begin
                  dns_next      = vshift_next;
                  dns_seen_next = 1'b1;
                end
              end
              if (off1 >= SUM_W'(nos)) begin
                phase_next = PH_TAG;
              end
            end
            PH_DONE: begin
              phase_next = PH_DONE;
            end
            default: begin
              phase_next = PH_DONE;
            end
          endcase
        end
      end

      if (in_data.last_byte) begin
        // Status checks in priority order; a rejected reply shows only its status.
        if (pos_next < POS_W'(TOTAL_BYTES)) begin
          res.status = ST_SHORT;
        end else if (!xid_ok_next) begin
          res.status = ST_XID;
        end else if (!magic_ok_next) begin
          res.status = ST_MAGIC;
        end else if (!port_ok_next) begin
          res.status = ST_PORT;
        end else begin
          res.status       = ST_ACCEPTED;
          res.message_type = msg_type_next;
          res.offered_ip   = offered_next;
          res.server_addr  = src_next;
          res.subnet_mask  = mask_next;
          res.mask_seen    = mask_seen_next;
          res.router_ip    = router_next;
          res.router_seen  = router_seen_next;
          res.dns_ip       = dns_next;
          res.dns_seen     = dns_seen_next;
        end

        // Clear the message state for the next reply.
        pos_next          = '0;
        hdr_next          = '0;
        xid_ok_next       = 1'b0;
        magic_ok_next     = 1'b0;
        port_ok_next      = 1'b0;
        src_next          = '0;
        offered_next      = '0;
        nos_next          = '0;
        phase_next        = PH_TAG;
        tag_next          = '0;
        vcnt_next         = '0;
        vshift_next       = '0;
        msg_type_next     = '0;
        type_pending_next = 1'b0;
        mask_next         = '0;
        mask_seen_next    = 1'b0;
        router_next       = '0;
        router_seen_next  = 1'b0;
        dns_next          = '0;
        dns_seen_next     = 1'b0;
      end
    end
  end

  // Transaction id register.
  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id <= '0;
    end else if (cfg_write_en) begin
      transaction_id <= cfg_write_data;
    end
  end

  // Message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      hdr          <= '0;
      xid_ok       <= 1'b0;
      magic_ok     <= 1'b0;
      port_ok      <= 1'b0;
      src          <= '0;
      offered      <= '0;
      nos          <= '0;
      phase        <= PH_TAG;
      tag          <= '0;
      vcnt         <= '0;
      vshift       <= '0;
      msg_type     <= '0;
      type_pending <= 1'b0;
      mask         <= '0;
      mask_seen    <= 1'b0;
      router       <= '0;
      router_seen  <= 1'b0;
      dns          <= '0;
      dns_seen     <= 1'b0;
    end else begin
      pos          <= pos_next;
      hdr          <= hdr_next;
      xid_ok       <= xid_ok_next;
      magic_ok     <= magic_ok_next;
      port_ok      <= port_ok_next;
      src          <= src_next;
      offered      <= offered_next;
      nos          <= nos_next;
      phase        <= phase_next;
      tag          <= tag_next;
      vcnt         <= vcnt_next;
      vshift       <= vshift_next;
      msg_type     <= msg_type_next;
      type_pending <= type_pending_next;
      mask         <= mask_next;
      mask_seen    <= mask_seen_next;
      router       <= router_next;
      router_seen  <= router_seen_next;
      dns          <= dns_next;
      dns_seen     <= dns_seen_next;
    end
  end

  // Result register: load on the last byte, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && in_data.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data <= res;
    end
  end

endmodule

@@ hw/rtl/dhcp_checker.sv @@
// Port-level assertions for the DHCP reply parser, bound to the top level.
module dhcp_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input dhcp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input dhcp_pkg::out_t out_data
);
  import dhcp_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A new result follows only a transfer of a last byte.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_byte))
    else $error("result without a last byte");

  // An empty output register always takes input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // A rejected reply carries nothing but its status.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_ACCEPTED |->
      out_data.message_type == '0 && out_data.offered_ip == '0 &&
      out_data.server_addr == '0 && !out_data.mask_seen &&
      !out_data.router_seen && !out_data.dns_seen)
    else $error("rejected reply carries fields");

  // An option not seen reads as zero.
  a_unseen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.mask_seen || out_data.subnet_mask == '0) &&
      (out_data.router_seen || out_data.router_ip == '0) &&
      (out_data.dns_seen || out_data.dns_ip == '0))
    else $error("absent option has a value");

endmodule

bind dhcp_reply_parser dhcp_checker u_dhcp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the DHCP reply parser: directed corner cases and random traffic.
module testbench;
  import dhcp_pkg::*;

  // Option area size used for both the instance and the reply predictor.
  localparam int AREA_BYTES = 312;
  localparam int FULL_LEN   = HEADER_BYTES + AREA_BYTES;
  // Hard stop for a hung run, far above the slowest legal run.
  localparam int WATCHDOG_TIME = 10_000_000;

  // Steps of the option walk inside the predictor.
  typedef enum logic [3:0] {
    WALK_TAG   = 4'b0001,
    WALK_LEN   = 4'b0010,
    WALK_VALUE = 4'b0100,
    WALK_DONE  = 4'b1000
  } walk_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;
  logic  cfg_write_en;
  logic  [31:0] cfg_write_data;

  dhcp_reply_parser #(.OPTION_AREA_BYTES(AREA_BYTES)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // ---------------------------------------------------------------------------
  // Reply predictor state: a private copy of the parser's per-message state
  // and of the transaction id register.
  // ---------------------------------------------------------------------------
  logic [31:0] xid_model;
  int          pos_cnt;
  logic [31:0] hdr_win;
  bit          xid_ok;
  bit          cookie_ok;
  bit          port_ok;
  logic [31:0] src_addr;
  int          opt_next;
  walk_t       walk_phase;
  logic [7:0]  opt_tag;
  int          opt_len;
  logic [31:0] val_acc;
  logic [31:0] addr_val [3];   // subnet, router, dns
  bit          addr_seen [3];
  logic [7:0]  type_val;
  logic [31:0] offer_val;
  bit          type_due;

  // Expected replies, oldest first.
  out_t replies_due[$];

  // Bytes of the reply being built by the stimulus tasks.
  logic [7:0] reply_buf[$];

  // Stimulus knobs and bookkeeping.
  logic [31:0] cur_xid;
  int send_idle_pct;
  int stall_pct;
  int hold_req;
  int error_count;
  int bytes_sent;
  int replies_sent;
  int replies_checked;
  int offers_ok;

  // Return all per-message state to its idle value; runs after every last byte.
  function void clear_reply();
    pos_cnt    = 0;
    hdr_win    = '0;
    xid_ok     = 1'b0;
    cookie_ok  = 1'b0;
    port_ok    = 1'b0;
    src_addr   = '0;
    opt_next   = 0;
    walk_phase = WALK_TAG;
    opt_tag    = '0;
    opt_len    = 0;
    val_acc    = '0;
    for (int k = 0; k < 3; k++) begin
      addr_val[k]  = '0;
      addr_seen[k] = 1'b0;
    end
    type_val  = '0;
    offer_val = '0;
    type_due  = 1'b0;
  endfunction

  // Advance the TLV walk by one byte at option-area offset off.
  function void walk_option(input int off, input logic [7:0] b);
    int idx;
    // An empty message type option takes whatever byte comes next.
    if (type_due) begin
      type_val = b;
      type_due = 1'b0;
    end
    case (walk_phase)
      WALK_TAG: begin
        // A tag on the final area byte can never carry a length: stop there.
        if (off + 1 >= AREA_BYTES || b == TAG_END) begin
          walk_phase = WALK_DONE;
        end else if (b != TAG_PAD) begin
          opt_tag    = b;
          walk_phase = WALK_LEN;
        end
      end
      WALK_LEN: begin
        // Drop an option that would run past the area and stop the walk.
        if (off + 1 + int'(b) > AREA_BYTES) begin
          walk_phase = WALK_DONE;
        end else begin
          opt_len  = int'(b);
          opt_next = off + 1 + int'(b);
          val_acc  = '0;
          if (opt_tag == TAG_MSGTYPE) begin
            if (off + 1 >= AREA_BYTES) type_val = '0;
            else type_due = 1'b1;
          end
          if (b == 8'd0) walk_phase = WALK_TAG;
          else walk_phase = WALK_VALUE;
        end
      end
      WALK_VALUE: begin
        idx = opt_len - (opt_next - off);
        if (idx < 4) val_acc = {val_acc[23:0], b};
        // Fourth value byte completes an address; later copies overwrite.
        if (idx == 3) begin
          case (opt_tag)
            TAG_SUBNET: begin
              addr_val[0]  = val_acc;
              addr_seen[0] = 1'b1;
            end
            TAG_ROUTER: begin
              addr_val[1]  = val_acc;
              addr_seen[1] = 1'b1;
            end
            TAG_DNS: begin
              addr_val[2]  = val_acc;
              addr_seen[2] = 1'b1;
            end
            default: ;
          endcase
        end
        if (off + 1 >= opt_next) walk_phase = WALK_TAG;
      end
      default: ;
    endcase
  endfunction

  // Take one accepted byte; on the last byte, produce the expected reply.
  function void absorb_byte(input in_t it, output bit fired, output out_t res);
    int p;
    p     = pos_cnt;
    fired = 1'b0;
    res   = '0;
    // Port and source address count only at the first byte of a message.
    if (p == 0) begin
      src_addr = it.source_ip;
      port_ok  = (it.source_port == SERVER_PORT);
    end
    // Bytes past the option area are ignored; the count saturates.
    if (p < FULL_LEN) begin
      hdr_win = {hdr_win[23:0], it.data_byte};
      if (p == XID_END_POS) xid_ok = (hdr_win == xid_model);
      else if (p == OFFER_END_POS) offer_val = hdr_win;
      else if (p == HEADER_BYTES - 1) cookie_ok = (hdr_win == MAGIC_COOKIE);
      else if (p >= HEADER_BYTES) walk_option(p - HEADER_BYTES, it.data_byte);
      pos_cnt = p + 1;
    end
    if (it.last_byte) begin
      fired = 1'b1;
      if (pos_cnt < FULL_LEN) res.status = ST_SHORT;
      else if (!xid_ok) res.status = ST_XID;
      else if (!cookie_ok) res.status = ST_MAGIC;
      else if (!port_ok) res.status = ST_PORT;
      else res.status = ST_ACCEPTED;
      // A rejected reply carries nothing but its status.
      if (res.status == ST_ACCEPTED) begin
        res.message_type = type_val;
        res.offered_ip   = offer_val;
        res.server_addr  = src_addr;
        res.subnet_mask  = addr_val[0];
        res.mask_seen    = addr_seen[0];
        res.router_ip    = addr_val[1];
        res.router_seen  = addr_seen[1];
        res.dns_ip       = addr_val[2];
        res.dns_seen     = addr_seen[2];
      end
      clear_reply();
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog and result side.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_TIME);
    $display("Timed out with %0d replies still expected", replies_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls at stall_pct, plus a long hold-off whenever a test
  // posts one in hold_req. The hold is counted down here.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: at each rising edge check the result transfer first, then apply
  // a register write, then feed an input transfer to the predictor. This fixed
  // order keeps the check independent of process scheduling.
  always @(posedge clk) begin : monitor
    bit   fired;
    out_t pred;
    out_t want;
    if (rst) begin
      xid_model = '0;
      clear_reply();
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("Result transfer with no reply expected: status %0d", out_data.status);
          error_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status",       32'(want.status),       32'(out_data.status));
          check_field("message_type", 32'(want.message_type), 32'(out_data.message_type));
          check_field("offered_ip",   want.offered_ip,        out_data.offered_ip);
          check_field("server_addr",  want.server_addr,       out_data.server_addr);
          check_field("subnet_mask",  want.subnet_mask,       out_data.subnet_mask);
          check_field("mask_seen",    32'(want.mask_seen),    32'(out_data.mask_seen));
          check_field("router_ip",    want.router_ip,         out_data.router_ip);
          check_field("router_seen",  32'(want.router_seen),  32'(out_data.router_seen));
          check_field("dns_ip",       want.dns_ip,            out_data.dns_ip);
          check_field("dns_seen",     32'(want.dns_seen),     32'(out_data.dns_seen));
          replies_checked++;
          if (want.status == ST_ACCEPTED) offers_ok++;
        end
      end
      if (cfg_write_en) xid_model = cfg_write_data;
      if (in_valid && in_ready) begin
        absorb_byte(in_data, fired, pred);
        if (fired) replies_due.push_back(pred);
        bytes_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one byte, with a random idle gap ahead of it; hold it until transfer.
  task send_byte(input in_t item);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 20) gap++;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Send reply_buf as one message; wobble changes port and address after the
  // first byte, which the parser must ignore.
  task send_reply(input logic [15:0] port, input logic [31:0] addr, input bit wobble);
    in_t item;
    for (int i = 0; i < reply_buf.size(); i++) begin
      item.data_byte   = reply_buf[i];
      item.last_byte   = (i == reply_buf.size() - 1);
      item.source_port = (wobble && i > 0) ? 16'($urandom_range(65535)) : port;
      item.source_ip   = (wobble && i > 0) ? $urandom : addr;
      send_byte(item);
    end
    replies_sent++;
  endtask

  // Drop valid and hold until every expected reply has come out.
  task drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_due.size() != 0);
  endtask

  // Write the transaction id only while the parser is idle.
  task write_xid(input logic [31:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    cur_xid = value;
  endtask

  // Select the sender idle and receiver stall percentages.
  task set_mix(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  task put_word(input int at, input logic [31:0] w);
    for (int k = 0; k < 4; k++) reply_buf[at + k] = w[31 - 8 * k -: 8];
  endtask

  // Random fixed header with the given transaction id and cookie.
  task start_reply(input logic [31:0] xid, input logic [31:0] cookie);
    reply_buf.delete();
    repeat (HEADER_BYTES) reply_buf.push_back(8'($urandom_range(255)));
    put_word(XID_END_POS - 3, xid);
    put_word(HEADER_BYTES - 4, cookie);
  endtask

  // Append one TLV option; value bytes past the first four are random.
  task put_opt(input logic [7:0] tag, input logic [7:0] len, input logic [31:0] word);
    reply_buf.push_back(tag);
    reply_buf.push_back(len);
    for (int k = 0; k < len; k++) begin
      if (k < 4) reply_buf.push_back(word[31 - 8 * k -: 8]);
      else reply_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  // Trim or extend the message to n bytes, padding with noise or pad tags.
  task size_to(input int n, input bit noisy);
    while (reply_buf.size() > n) void'(reply_buf.pop_back());
    while (reply_buf.size() < n) begin
      if (noisy) reply_buf.push_back(8'($urandom_range(255)));
      else reply_buf.push_back(TAG_PAD);
    end
  endtask

  // Random option area: mostly known options of useful lengths, some pads,
  // stray tags, rare end tags and options long enough to overrun the area.
  task random_area();
    int pick;
    logic [7:0] tag;
    while (reply_buf.size() < FULL_LEN) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        reply_buf.push_back(TAG_PAD);
      end else if (pick < 12) begin
        reply_buf.push_back(TAG_END);
      end else if (pick < 28) begin
        put_opt(TAG_MSGTYPE, (pick < 24) ? 8'd1 : 8'($urandom_range(3)), $urandom);
      end else if (pick < 76) begin
        case ($urandom_range(2))
          0: tag = TAG_SUBNET;
          1: tag = TAG_ROUTER;
          default: tag = TAG_DNS;
        endcase
        pick = $urandom_range(99);
        if (pick < 70) put_opt(tag, 8'd4, $urandom);
        else if (pick < 85) put_opt(tag, 8'($urandom_range(3)), $urandom);
        else put_opt(tag, 8'($urandom_range(12, 5)), $urandom);
      end else if (pick < 96) begin
        put_opt(8'($urandom_range(255)), 8'($urandom_range(16)), $urandom);
      end else begin
        put_opt(8'($urandom_range(255)), 8'($urandom_range(255, 17)), $urandom);
      end
    end
    size_to(FULL_LEN, 1'b1);
  endtask

  // A few short noise messages with a wandering port and address.
  task send_short(input int count);
    repeat (count) begin
      reply_buf.delete();
      size_to($urandom_range(12, 1), 1'b1);
      send_reply(16'($urandom_range(65535)), $urandom, 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Option walk corners in one clean reply on the reset transaction id:
  // pads, skipped short options, overwrites, an overlong option that stops
  // the walk, and a tail of bytes past the area that must not count.
  task test_option_walk();
    set_mix(0, 0);
    start_reply(cur_xid, MAGIC_COOKIE);
    repeat (3) reply_buf.push_back(TAG_PAD);
    put_opt(TAG_MSGTYPE, 8'd1, 32'h0200_0000);
    put_opt(TAG_SUBNET, 8'd3, $urandom);
    put_opt(TAG_SUBNET, 8'd4, 32'hFFFF_FF00);
    put_opt(TAG_ROUTER, 8'd8, 32'hC0A8_0001);
    put_opt(TAG_DNS, 8'd4, 32'h0A00_0001);
    put_opt(TAG_DNS, 8'd4, 32'h0A00_0002);
    put_opt(TAG_MSGTYPE, 8'd1, 32'h0500_0000);
    put_opt(TAG_ROUTER, 8'd2, $urandom);
    put_opt(TAG_ROUTER, 8'd0, 32'd0);
    put_opt(8'd200, 8'd5, $urandom);
    size_to(HEADER_BYTES + 200, 1'b0);
    reply_buf.push_back(TAG_ROUTER);
    reply_buf.push_back(8'd255);
    put_opt(TAG_SUBNET, 8'd4, $urandom);
    size_to(FULL_LEN + 4, 1'b1);
    send_reply(SERVER_PORT, $urandom, 1'b1);
  endtask

  // Short messages, a single byte among them, with an idle sender.
  task test_short_messages();
    set_mix(45, 0);
    reply_buf.delete();
    reply_buf.push_back(8'hFF);
    send_reply(SERVER_PORT, 32'hFFFF_FFFF, 1'b0);
    send_short(6);
  endtask

  // All-ones id, address and option values under receiver stalls; an empty
  // message type first takes the next tag, and one on the last two area
  // bytes clears the type again.
  task test_config_extremes();
    set_mix(0, 45);
    write_xid(32'hFFFF_FFFF);
    start_reply(cur_xid, MAGIC_COOKIE);
    put_word(OFFER_END_POS - 3, 32'hFFFF_FFFF);
    put_opt(TAG_MSGTYPE, 8'd0, 32'd0);
    put_opt(TAG_SUBNET, 8'd4, 32'hFFFF_FFFF);
    put_opt(TAG_ROUTER, 8'd4, 32'hFFFF_FFFF);
    put_opt(TAG_DNS, 8'd4, 32'hFFFF_FFFF);
    put_opt(TAG_MSGTYPE, 8'd1, 32'hFF00_0000);
    size_to(FULL_LEN - 2, 1'b0);
    reply_buf.push_back(TAG_MSGTYPE);
    reply_buf.push_back(8'd0);
    send_reply(SERVER_PORT, 32'hFFFF_FFFF, 1'b0);
    send_short(3);
  endtask

  // Id and cookie pass but the port differs in its top bit: the last check
  // in the priority order rejects the reply. Both sides pause at random.
  task test_header_fault();
    set_mix(19, 19);
    write_xid($urandom);
    start_reply(cur_xid, MAGIC_COOKIE);
    random_area();
    send_reply(SERVER_PORT ^ 16'h8000, $urandom, 1'b0);
    send_short(3);
  endtask

  // Hold the output off for a long stretch while short messages keep coming,
  // so the result register fills and the input stalls.
  task test_backpressure();
    set_mix(0, 0);
    hold_req = 200;
    repeat (8) begin
      reply_buf.delete();
      size_to($urandom_range(3, 1), 1'b1);
      send_reply(16'($urandom_range(65535)), $urandom, 1'b0);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : main
    int waited;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    cur_xid        = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 0;
    error_count    = 0;
    bytes_sent     = 0;
    replies_sent   = 0;
    replies_checked = 0;
    offers_ok      = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first test runs on the reset value of the transaction id.
    test_option_walk();
    test_short_messages();
    test_config_extremes();
    test_header_fault();
    test_backpressure();

    // Let the last results out, then check that none is still expected.
    in_valid <= 1'b0;
    stall_pct = 0;
    waited = 0;
    while (replies_due.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (5) @(negedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d expected replies never came out", replies_due.size());
      error_count++;
    end

    $display("Sent %0d byte transfers in %0d messages: option walk, extremes, port fault,",
             bytes_sent, replies_sent);
    $display("short messages and a long output stall; checked %0d results, %0d accepted, %0d errors.",
             replies_checked, offers_ok, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
